/* design/mm3_pkg.sv */
// Shared types and constants of the square matrix multiply unit.
// No dependencies; mm3_mac, the top level and the checker refer to this package by scoped names.
package mm3_pkg;

    localparam int DIM_DEFAULT = 3;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int IDX_W       = 2;
    localparam int MODE_W      = 2;
    localparam int Q_SHIFT     = 16;
    localparam int TDATA_W     = 40;

    localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Tag that travels with each operand pair through the multiply-accumulate pipe.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_tag_t;

    // Status of the finished dot product.
    typedef struct packed {
        logic done;
        logic saturated;
    } mac_status_t;

endpackage

/* design/mm3_ram.sv */
// Single write port, single registered read port storage for one matrix.
// Depends on nothing beyond its parameters.
module mm3_ram #(
    parameter int DEPTH = 9,
    parameter int AW    = 4,
    parameter int W     = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/mm3_mac.sv */
// Shared multiply-accumulate unit with Q16.16 rescaling and saturation.
// Depends on mm3_pkg for widths and the tag and status structs.
module mm3_mac #(
    parameter int ACC_W = 66
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mm3_pkg::mac_tag_t                 tag,
    input  logic signed [mm3_pkg::DATA_W-1:0] a,
    input  logic signed [mm3_pkg::DATA_W-1:0] b,
    output mm3_pkg::mac_status_t              status,
    output logic [mm3_pkg::DATA_W-1:0]        value
);

    localparam int SH_W = ACC_W - mm3_pkg::Q_SHIFT;

    mm3_pkg::mac_tag_t tag_d_reg;
    mm3_pkg::mac_tag_t tag_p_reg;
    logic signed [mm3_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [ACC_W-1:0]           prod_ext;
    logic                              acc_done_reg;
    logic [mm3_pkg::DATA_W-1:0]        res_value_reg;
    logic [mm3_pkg::DATA_W-1:0]        res_value_next;
    logic                              res_sat_reg;
    logic                              res_sat_next;
    logic                              res_done_reg;
    logic [SH_W-1:0]                   shifted;
    logic [SH_W-mm3_pkg::DATA_W:0]     upper;

    // The RAM read data is registered, so the tag goes through tag_d_reg to match it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg    <= '0;
            tag_p_reg    <= '0;
            acc_done_reg <= 1'b0;
            res_done_reg <= 1'b0;
        end
        else
        begin
            tag_d_reg    <= tag;
            tag_p_reg    <= tag_d_reg;
            acc_done_reg <= tag_p_reg.valid & tag_p_reg.last;
            res_done_reg <= acc_done_reg;
        end
    end

    always_comb
    begin
        prod_ext = {{(ACC_W - mm3_pkg::PROD_W){prod_reg[mm3_pkg::PROD_W-1]}}, prod_reg};
        acc_next = tag_p_reg.first ? prod_ext : acc_reg + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        if (tag_d_reg.valid)
        begin
            prod_reg <= a * b;
        end
        if (tag_p_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (acc_done_reg)
        begin
            res_value_reg <= res_value_next;
            res_sat_reg   <= res_sat_next;
        end
    end

    // Drop the low fraction bits, then clip when the bits above Q16.16 are not a sign extension.
    always_comb
    begin
        shifted = acc_reg[ACC_W-1:mm3_pkg::Q_SHIFT];
        upper   = shifted[SH_W-1:mm3_pkg::DATA_W-1];
        if ((&upper) || !(|upper))
        begin
            res_value_next = shifted[mm3_pkg::DATA_W-1:0];
            res_sat_next   = 1'b0;
        end
        else
        begin
            res_value_next = acc_reg[ACC_W-1] ? {1'b1, {(mm3_pkg::DATA_W-1){1'b0}}}
                                              : {1'b0, {(mm3_pkg::DATA_W-1){1'b1}}};
            res_sat_next   = 1'b1;
        end
    end

    assign status.done      = res_done_reg;
    assign status.saturated = res_sat_reg;
    assign value            = res_value_reg;

endmodule

/* design/matrix_multiply_3x3_unit.sv */
// Square matrix multiply unit: a compute beat emits DIM*DIM beats.
// Each product element issues DIM operand pairs, drains through the RAM read, product,
// accumulator and result registers, then waits in the output register until it is taken;
// the single shared multiplier computes the elements one after another.
// Reset is asynchronous and active low; it clears the sequencer but not the matrix stores.
module matrix_multiply_3x3_unit #(
    parameter int DIM = mm3_pkg::DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata from bit 0 up: row[1:0], col[3:2], value[35:4], zero pad[39:36]
    input  logic [mm3_pkg::TDATA_W-1:0] s_tdata,
    // s_tuser: mode[1:0]
    input  logic [mm3_pkg::MODE_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata from bit 0 up: out_row[1:0], out_col[3:2], product_value[35:4], zero pad[39:36]
    output logic [mm3_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: saturated
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DIM);
    localparam int ACC_W = mm3_pkg::PROD_W + $clog2(DIM);
    localparam logic [CW-1:0] LAST_IDX = CW'(DIM - 1);

    mm3_pkg::state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;

    logic [mm3_pkg::IDX_W-1:0]  in_row;
    logic [mm3_pkg::IDX_W-1:0]  in_col;
    logic [mm3_pkg::DATA_W-1:0] in_value;
    logic                       in_fire;
    logic                       in_range;
    logic                       we_a;
    logic                       we_b;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr_a;
    logic [AW-1:0]              raddr_b;
    logic [mm3_pkg::DATA_W-1:0] rdata_a;
    logic [mm3_pkg::DATA_W-1:0] rdata_b;
    logic [mm3_pkg::DATA_W-1:0] prod_value;
    logic                       elem_last;

    mm3_pkg::mac_tag_t    issue_tag;
    mm3_pkg::mac_status_t mac_status;

    assign in_row   = s_tdata[1:0];
    assign in_col   = s_tdata[3:2];
    assign in_value = s_tdata[35:4];
    assign in_fire  = s_tvalid & s_tready;
    // Writes outside the matrix are dropped without a trace.
    assign in_range = (32'(in_row) < DIM) && (32'(in_col) < DIM);
    assign waddr    = AW'(32'(in_row) * DIM + 32'(in_col));
    assign we_a     = in_fire && in_range && (s_tuser == mm3_pkg::MODE_WRITE_A);
    assign we_b     = in_fire && in_range && (s_tuser == mm3_pkg::MODE_WRITE_B);

    // Row i of A walks along k, column j of B walks down k.
    assign raddr_a  = AW'(32'(i_reg) * DIM + 32'(k_reg));
    assign raddr_b  = AW'(32'(k_reg) * DIM + 32'(j_reg));

    assign elem_last = (i_reg == LAST_IDX) && (j_reg == LAST_IDX);

    mm3_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (mm3_pkg::DATA_W)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mm3_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (mm3_pkg::DATA_W)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    mm3_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (issue_tag),
        .a      (rdata_a),
        .b      (rdata_b),
        .status (mac_status),
        .value  (prod_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm3_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Sequencer: issue one operand pair a cycle, wait for the pipe to drain, then hold the
    // finished element until its beat is taken.
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        issue_tag.valid = 1'b0;
        issue_tag.first = (k_reg == '0);
        issue_tag.last  = (k_reg == LAST_IDX);
        unique case (state_reg)
            mm3_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == mm3_pkg::MODE_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = mm3_pkg::ST_RUN;
                end
            end
            mm3_pkg::ST_RUN:
            begin
                issue_tag.valid = 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    k_next     = '0;
                    state_next = mm3_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mm3_pkg::ST_DRAIN:
            begin
                if (mac_status.done)
                begin
                    state_next = mm3_pkg::ST_OUT;
                end
            end
            mm3_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (elem_last)
                    begin
                        state_next = mm3_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mm3_pkg::ST_RUN;
                        if (j_reg == LAST_IDX)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mm3_pkg::ST_IDLE;
            end
        endcase
    end

    // The element registers in the shared unit and the counters hold steady during the beat.
    assign m_tdata = {4'b0000, prod_value,
                      mm3_pkg::IDX_W'(j_reg), mm3_pkg::IDX_W'(i_reg)};
    assign m_tuser = mac_status.saturated;
    assign m_tlast = elem_last;

endmodule

/* design/mm3_checker.sv */
// Port-level checks for the matrix multiply unit, bound to the top level.
// Depends on mm3_pkg for port widths and on matrix_multiply_3x3_unit for the bind.
module mm3_checker #(
    parameter int DIM = mm3_pkg::DIM_DEFAULT
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mm3_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);

    localparam logic [mm3_pkg::IDX_W-1:0] LAST_IDX = mm3_pkg::IDX_W'(DIM - 1);

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result beat changed while stalled");

    // The unit never takes a new beat while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

    // A saturated element sits at one of the two Q16.16 limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[35:4] == 32'h7FFF_FFFF)
            || (m_tdata[35:4] == 32'h8000_0000))
    else $error("saturated flag without a clipped value");

    // The final element is the bottom-right one, and the unit is ready again after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[1:0] == LAST_IDX) && (m_tdata[3:2] == LAST_IDX))
    else $error("last mark on the wrong element");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not ready after the final result beat");

endmodule

bind matrix_multiply_3x3_unit mm3_checker #(
    .DIM (DIM)
) u_mm3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/mm3_product_ledger_pkg.sv */
// Scoreboard for the square matrix multiply unit: it mirrors both operand matrices and
// queues the product beats that every accepted compute beat should bring back.
// Depends on mm3_pkg for the field widths and the mode codes.
`timescale 1ns / 1ps
package mm3_product_ledger_pkg;

    import mm3_pkg::*;

    localparam int SIDE  = DIM_DEFAULT;
    localparam int CELLS = SIDE * SIDE;

    // Bit positions of the fields within tdata, on both the load and the product side.
    localparam int COL_LSB   = IDX_W;
    localparam int VALUE_LSB = 2 * IDX_W;
    localparam int PAD_LSB   = 2 * IDX_W + DATA_W;

    // Three full-width products fit in two extra bits; the shift leaves the rest.
    localparam int SUM_W    = PROD_W + 2;
    localparam int SCALED_W = SUM_W - Q_SHIFT;
    localparam logic signed [SCALED_W-1:0] SCALED_TOP =
        {{(SCALED_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SCALED_W-1:0] SCALED_BOTTOM =
        {{(SCALED_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef struct {
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic [DATA_W-1:0] product_value;
        logic              saturated;
        logic              last;
    } product_beat_t;

    class matrix_product_ledger;
        logic signed [DATA_W-1:0] left_cells[CELLS];
        logic signed [DATA_W-1:0] right_cells[CELLS];
        product_beat_t            awaited[$];
        int                       mismatches;

        function new();
            mismatches = 0;
            foreach (left_cells[i])
            begin
                left_cells[i]  = '0;
                right_cells[i] = '0;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Row r of A against column c of B, summed exactly, scaled back to Q16.16 and clipped.
        function void product_element(int r, int c, output logic [DATA_W-1:0] value,
                                      output logic clipped);
            logic signed [SUM_W-1:0]    dot_sum;
            logic signed [SCALED_W-1:0] scaled;
            dot_sum = '0;
            for (int k = 0; k < SIDE; k++)
                dot_sum = dot_sum + left_cells[r * SIDE + k] * right_cells[k * SIDE + c];
            scaled  = SCALED_W'(dot_sum >>> Q_SHIFT);
            clipped = 1'b1;
            if (scaled > SCALED_TOP)
                value = {1'b0, {(DATA_W - 1){1'b1}}};
            else if (scaled < SCALED_BOTTOM)
                value = {1'b1, {(DATA_W - 1){1'b0}}};
            else
            begin
                value   = scaled[DATA_W-1:0];
                clipped = 1'b0;
            end
        endfunction

        // Called for every beat that the unit accepts, whatever its mode.
        function void take_beat(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic [DATA_W-1:0] value);
            product_beat_t beat;
            int            slot;
            slot = int'(row) * SIDE + int'(col);
            if (mode == MODE_COMPUTE)
            begin
                for (int r = 0; r < SIDE; r++)
                    for (int c = 0; c < SIDE; c++)
                    begin
                        beat.out_row = IDX_W'(r);
                        beat.out_col = IDX_W'(c);
                        product_element(r, c, beat.product_value, beat.saturated);
                        beat.last = (r == SIDE - 1) && (c == SIDE - 1);
                        awaited.push_back(beat);
                    end
            end
            else if (row < SIDE && col < SIDE)
            begin
                if (mode == MODE_WRITE_A)
                    left_cells[slot] = value;
                else if (mode == MODE_WRITE_B)
                    right_cells[slot] = value;
            end
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: product mismatch: %s", $time, what);
        endfunction

        // Called for every product beat that leaves the unit.
        function void compare_element(logic [TDATA_W-1:0] tdata, logic tuser, logic tlast);
            product_beat_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("beat tdata %h with no product awaited", tdata));
                return;
            end
            want = awaited.pop_front();
            if (tdata[IDX_W-1:0] !== want.out_row || tdata[COL_LSB +: IDX_W] !== want.out_col
                || tdata[VALUE_LSB +: DATA_W] !== want.product_value
                || tdata[TDATA_W-1:PAD_LSB] !== '0
                || tuser !== want.saturated || tlast !== want.last)
                report_mismatch($sformatf(
                    "expected (%0d,%0d) %h sat %b last %b, got (%0d,%0d) %h sat %b last %b pad %h",
                    want.out_row, want.out_col, want.product_value, want.saturated, want.last,
                    tdata[IDX_W-1:0], tdata[COL_LSB +: IDX_W], tdata[VALUE_LSB +: DATA_W],
                    tuser, tlast, tdata[TDATA_W-1:PAD_LSB]));
        endfunction
    endclass

endpackage

/* tb/sv/matrix_multiply_3x3_unit_test.sv */
// Top-level testbench of the square matrix multiply unit: loads and compute beats go in on the
// slave stream, product beats are checked against a mirrored model as they come out.
// Depends on mm3_pkg, mm3_product_ledger_pkg and the unit itself.
`timescale 1ns / 1ps
module matrix_multiply_3x3_unit_test;

    import mm3_pkg::*;
    import mm3_product_ledger_pkg::*;

    // Mode 3 has no meaning to the unit; it must be swallowed without effect.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Index one past the last row or column, which a load must ignore.
    localparam logic [IDX_W-1:0]  IDX_BEYOND  = 2'd3;
    localparam logic [DATA_W-1:0] Q_LARGEST   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_SMALLEST  = 32'h8000_0000;

    // Loads and computes issued by the random part; ignored beats come on top of these.
    localparam int RANDOM_BEATS  = 325;
    // Extra time after the last product, so that any straggling beat is still seen.
    localparam int SETTLE_CYCLES = 150;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PATTERN,
        READY_SPARSE
    } ready_style_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]  s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    matrix_product_ledger products = new();

    int           burst_left    = 0;
    int unsigned  stall_stretch = 0;
    ready_style_t stall_style   = READY_ALWAYS;
    logic [31:0]  stall_pattern = '0;

    matrix_multiply_3x3_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both handshakes are observed in one process, and always from the values held across
    // the edge, so a load beat is booked before any product beat of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                products.take_beat(s_tuser, s_tdata[IDX_W-1:0], s_tdata[COL_LSB +: IDX_W],
                                   s_tdata[VALUE_LSB +: DATA_W]);
            if (m_tvalid && m_tready)
                products.compare_element(m_tdata, m_tuser, m_tlast);
        end
    end

    // The receiver changes its manner from one random stretch to the next: always ready, a coin
    // toss per cycle, a rotating 32-bit pattern, or mostly stalled. The pattern can hold it off for a
    // long stretch, which keeps finished elements waiting in the output register.
    always @(posedge clk)
    begin
        if (stall_stretch == 0)
        begin
            stall_stretch <= $urandom_range(16, 96);
            stall_style   <= ready_style_t'($urandom_range(0, 3));
            stall_pattern <= $urandom;
            m_tready      <= 1'b1;
        end
        else
        begin
            stall_stretch <= stall_stretch - 1;
            case (stall_style)
                READY_ALWAYS:
                    m_tready <= 1'b1;
                READY_COIN:
                    m_tready <= 1'($urandom);
                READY_PATTERN:
                begin
                    m_tready      <= stall_pattern[0];
                    stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
                end
                default:
                    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offers one beat and returns at the edge that takes it. Beats come in bursts; when a
    // burst runs out the sender may drop tvalid before the next one starts.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(TDATA_W - PAD_LSB){1'b0}}, value, col, row};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds the sender off until every awaited product beat has been seen. The count is read
    // at the falling edge, where nothing else is moving, and the task ends on a rising edge.
    task automatic wait_for_products();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (products.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Element values of every magnitude: a random bit count, sign-extended, so that many dot
    // products stay in range while others overflow, plus the extremes and zero now and then.
    function automatic logic [DATA_W-1:0] pick_element();
        int unsigned pick;
        int unsigned bits;
        logic [DATA_W-1:0] raw;
        pick = $urandom_range(0, 19);
        raw  = $urandom;
        if (pick == 0)
            return Q_LARGEST;
        if (pick == 1)
            return Q_SMALLEST;
        if (pick == 2)
            return '0;
        bits = $urandom_range(1, DATA_W);
        return DATA_W'($signed(raw << (DATA_W - bits)) >>> (DATA_W - bits));
    endfunction

    initial
    begin
        int unsigned      issued;
        int unsigned      kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Both matrices at the largest value: every element overflows upwards. The stores
        // must be filled completely before any compute beat reads them.
        for (int slot = 0; slot < CELLS; slot++)
            send_beat(MODE_WRITE_A, IDX_W'(slot / SIDE), IDX_W'(slot % SIDE), Q_LARGEST);
        for (int slot = 0; slot < CELLS; slot++)
            send_beat(MODE_WRITE_B, IDX_W'(slot / SIDE), IDX_W'(slot % SIDE), Q_LARGEST);

        // Loads outside the matrix and a beat in the unused mode; any of them landing in a
        // store would show up in the product below.
        send_beat(MODE_WRITE_A, IDX_BEYOND, '0, Q_SMALLEST);
        send_beat(MODE_WRITE_B, 2'd1, IDX_BEYOND, Q_SMALLEST);
        send_beat(MODE_UNUSED, '0, '0, Q_SMALLEST);

        // The compute beat carries junk in its index and value fields, which must not matter.
        send_beat(MODE_COMPUTE, IDX_BEYOND, IDX_BEYOND, '1);
        wait_for_products();

        // Two most-negative entries in column 0 of B drive that column below the range, and
        // the second compute also repeats every other element from the unchanged stores.
        send_beat(MODE_WRITE_B, 2'd1, 2'd0, Q_SMALLEST);
        send_beat(MODE_WRITE_B, 2'd2, 2'd0, Q_SMALLEST);
        send_beat(MODE_COMPUTE, '0, '0, '0);

        // Mostly loads at valid positions with a compute now and then, salted with ignored
        // beats. After some computes the sender waits for the whole product to drain.
        issued = 0;
        while (issued < RANDOM_BEATS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 9)
            begin
                send_beat(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                issued++;
                if ($urandom_range(0, 7) == 0)
                    wait_for_products();
            end
            else if (kind < 12)
            begin
                send_beat(MODE_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end
            else if (kind < 15)
            begin
                row = IDX_W'($urandom_range(0, 3));
                col = (row == IDX_BEYOND) ? IDX_W'($urandom) : IDX_BEYOND;
                send_beat(($urandom_range(0, 1) == 0) ? MODE_WRITE_A : MODE_WRITE_B,
                          row, col, $urandom);
            end
            else
            begin
                send_beat(($urandom_range(0, 1) == 0) ? MODE_WRITE_A : MODE_WRITE_B,
                          IDX_W'($urandom_range(0, SIDE - 1)),
                          IDX_W'($urandom_range(0, SIDE - 1)), pick_element());
                issued++;
            end
        end
        // A closing compute so that the last loads are seen in a product too.
        send_beat(MODE_COMPUTE, '0, '0, '0);

        wait_for_products();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (products.mismatches == 0 && products.pending() == 0)
            $display("matrix_multiply_3x3_unit test passed");
        else
            $display("matrix_multiply_3x3_unit test failed");
        $finish;
    end

    // Even with every beat a compute and the receiver at its slowest, the run ends well
    // inside this bound.
    initial
    begin
        #10ms;
        $display("matrix_multiply_3x3_unit test failed");
        $finish;
    end

endmodule
